// ===== design/ftn_pkg.sv =====
// Shared constants and types for the frame timestamp normalizer.
package ftn_pkg;
  localparam int unsigned CountBits = 32;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [19:0] DefaultCadenceUs = 20'd33333;
  localparam logic [19:0] MinCadenceUs = 20'd1000;
  localparam logic [19:0] MaxCadenceUs = 20'd1000000;
  localparam logic [20:0] UsPerSecond = 21'd1000000;
  localparam logic [0:0] CfgTimebaseNum = 1'b0;
  localparam logic [0:0] CfgTimebaseDen = 1'b1;

  // Start request and operand value sent from the sequencer to the rescale unit.
  typedef struct packed {
    logic start;
    logic [63:0] value;
  } ftn_rs_req_t;
endpackage

// ===== design/frame_timestamp_normalizer.sv =====
// Top level of the frame timestamp normalizer: sequencer, history state and stream ports.
// One request is taken at a time. The four timestamps (presentation, best-effort,
// decode, duration) go one after another through a single bit-serial rescale unit:
// a launch, a shift-add multiply, a restoring divide and a hand-off back to the
// sequencer. An absent timestamp or a duration that is not positive skips its slot
// without a rescale; with a zero denominator the unit skips the multiply and divide
// and returns the minimum value. The serial multiply and divide set the time per
// request. The result sits in an output register, and the next request is taken
// only after that result has been taken.
// tdata of the result is the time fields packed low to high; tuser holds the flag bits.
module frame_timestamp_normalizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] pts_raw, [127:64] best_effort_raw, [191:128] dts_raw, [255:192] duration_raw
  input  logic [255:0] in_tdata,
  // [0] pts_valid, [1] best_effort_valid, [2] dts_valid
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] out_time_us, [127:64] pts_us, [191:128] be_us,
  // [223:192] adjustment_total, [287:224] dts_us, [351:288] dur_us
  output logic [351:0] out_tdata,
  // [0] raw_available, [1] be_present, [2] be_chosen, [3] adjusted
  output logic [3:0]   out_tuser
);
  import ftn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LAUNCH, S_WAIT, S_DECIDE, S_OUT} st_t;

  st_t          state_r;
  logic [1:0]   sel_r;
  logic [30:0]  tb_num_r, tb_den_r;
  logic [255:0] in_r;
  logic [2:0]   vld_r;
  logic [63:0]  raw_r, be_r, dts_r, dur_r;
  logic [63:0]  last_r;
  logic         last_vld_r;
  logic [19:0]  cad_r;
  logic         cad_vld_r;
  logic [CountBits-1:0] cnt_r;
  logic [351:0] odata_r;
  logic [3:0]   ouser_r;
  ftn_rs_req_t  rs_req;
  logic         rs_done;
  logic [63:0]  rs_res;
  logic [63:0]  sel_val;
  logic         skip;

  // Pick the field for the current rescale slot; absent timestamps or a non-positive duration skip.
  always_comb begin
    sel_val = in_r[64*sel_r +: 64];
    case (sel_r)
      2'd0: skip = !vld_r[0];
      2'd1: skip = !vld_r[1];
      2'd2: skip = !vld_r[2];
      default: skip = in_r[255] || (in_r[255:192] == 64'd0);
    endcase
  end

  assign rs_req.start = (state_r == S_LAUNCH) && !skip;
  assign rs_req.value = sel_val;

  ftn_rescale u_rescale (
    .clk(clk), .rst_n(rst_n), .req(rs_req), .tb_num(tb_num_r), .tb_den(tb_den_r),
    .done(rs_done), .result(rs_res)
  );

  // Candidate selection, correction step, monotonic forcing and frame interval observation.
  logic         sane, step_ok;
  logic [63:0]  step, sat_sum, cand, delta;
  logic         adj, later, obs;
  logic [21:0]  cad4;
  always_comb begin
    sane = !dur_r[63] && (dur_r >= 64'(MinCadenceUs)) && (dur_r <= 64'(MaxCadenceUs));
    cad4 = {cad_r, 2'b00};
    step_ok = (dur_r[19:0] >= {2'b00, cad_r[19:2]}) && (dur_r[21:0] <= cad4);
    if (!cad_vld_r) step = sane ? dur_r : 64'(DefaultCadenceUs);
    else if (sane && step_ok) step = dur_r;
    else step = 64'(cad_r);
    if ($signed(PosMax - step) < $signed(last_r)) sat_sum = PosMax;
    else sat_sum = last_r + step;
    adj = 1'b0;
    if (vld_r[1]) cand = be_r;
    else if (vld_r[0]) cand = raw_r;
    else begin
      adj = 1'b1;
      cand = last_vld_r ? sat_sum : 64'd0;
    end
    later = $signed(last_r) < $signed(cand);
    delta = cand - last_r;
    obs = 1'b0;
    if (last_vld_r) begin
      if (!later) begin
        cand = sat_sum;
        adj = 1'b1;
      end else if (delta >= 64'(MinCadenceUs) && delta <= 64'(MaxCadenceUs) &&
                   (!cad_vld_r || delta < 64'(cad_r))) begin
        obs = 1'b1;
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Apply config writes, sequence the four rescales, then update history and hold the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tb_num_r <= 31'd1;
      tb_den_r <= 31'(UsPerSecond);
      last_vld_r <= 1'b0;
      last_r <= '0;
      cad_r <= '0;
      cad_vld_r <= 1'b0;
      cnt_r <= '0;
      sel_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTimebaseNum: tb_num_r <= cfg_data;
          CfgTimebaseDen: tb_den_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_r <= in_tdata;
            vld_r <= in_tuser;
            sel_r <= 2'd0;
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          if (skip) begin
            case (sel_r)
              2'd0: raw_r <= '0;
              2'd1: be_r <= '0;
              2'd2: dts_r <= sel_val;
              default: dur_r <= sel_val;
            endcase
            if (sel_r == 2'd3) state_r <= S_DECIDE;
            sel_r <= sel_r + 2'd1;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rs_done) begin
            case (sel_r)
              2'd0: raw_r <= rs_res;
              2'd1: be_r <= rs_res;
              2'd2: dts_r <= rs_res;
              default: dur_r <= rs_res;
            endcase
            state_r <= (sel_r == 2'd3) ? S_DECIDE : S_LAUNCH;
            sel_r <= sel_r + 2'd1;
          end
        end
        S_DECIDE: begin
          last_r <= cand;
          last_vld_r <= 1'b1;
          if (obs) begin
            cad_r <= delta[19:0];
            cad_vld_r <= 1'b1;
          end
          if (adj) cnt_r <= cnt_r + 1'b1;
          odata_r <= {dur_r, dts_r, 32'(cnt_r + CountBits'(adj)), be_r, raw_r, cand};
          ouser_r <= {adj, vld_r[1], vld_r[1], vld_r[0]};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
endmodule

// ===== design/ftn_mul.sv =====
// Bit-serial multiplier: 64-bit magnitude times 51-bit scale, one bit per cycle.
module ftn_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  mag,
  input  logic [50:0]  scale,
  output logic         done,
  output logic [114:0] product
);
  import ftn_pkg::*;

  logic [114:0] acc_r, acc_nxt;
  logic [63:0]  mag_r, mag_nxt;
  logic [50:0]  scl_r, scl_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  // Shift the scale right, add the shifted magnitude for each set bit.
  always_comb begin
    acc_nxt = acc_r;
    mag_nxt = mag_r;
    scl_nxt = scl_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mag_nxt = mag;
      scl_nxt = scale;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (scl_r[0]) begin
        acc_nxt = acc_r + ({51'd0, mag_r} << cnt_r);
      end
      scl_nxt = scl_r >> 1;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd50) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mag_r <= mag_nxt;
    scl_r <= scl_nxt;
  end

  assign done = done_r;
  assign product = acc_r;
endmodule

// ===== design/ftn_div.sv =====
// Restoring divider: 116-bit dividend by 31-bit divisor, one quotient bit per cycle.
module ftn_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [115:0] dividend,
  input  logic [30:0]  divisor,
  output logic         done,
  output logic [115:0] quotient
);
  import ftn_pkg::*;

  logic [115:0] quo_r, quo_nxt;
  logic [31:0]  rem_r, rem_nxt;
  logic [30:0]  dvs_r, dvs_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  trial;

  // Shift one dividend bit into the remainder, subtract when it fits.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[30:0], quo_r[115]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[114:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[114:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd115) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;
endmodule

// ===== design/ftn_rescale.sv =====
// Rescale unit: round(t * num * 1e6 / den), ties away from zero, min value on overflow.
module ftn_rescale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ftn_pkg::ftn_rs_req_t req,
  input  logic [30:0]          tb_num,
  input  logic [30:0]          tb_den,
  output logic                 done,
  output logic [63:0]          result
);
  import ftn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} rs_state_t;

  rs_state_t    state_r;
  logic         neg_r;
  logic         done_r;
  logic [63:0]  result_r;
  logic [63:0]  mag;
  logic [50:0]  scale;
  logic         mul_done, div_done;
  logic [114:0] product;
  logic [115:0] quotient;
  logic         div_start;
  logic [115:0] dividend;
  logic         zero_den;

  assign zero_den = (tb_den == 31'd0);
  assign mag = !req.value[63] ? req.value :
               (req.value == SignBit) ? PosMax : (64'd0 - req.value);
  assign scale = 51'(tb_num) * 51'(UsPerSecond);
  assign dividend = {1'b0, product} + {86'd0, tb_den[30:1]};
  assign div_start = mul_done;

  ftn_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(req.start && !zero_den), .mag(mag),
    .scale(scale), .done(mul_done), .product(product)
  );

  ftn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(tb_den), .done(div_done), .quotient(quotient)
  );

  // Sequence multiply then divide, then sign and range check; a zero denominator returns the min value directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            neg_r <= req.value[63];
            if (zero_den) begin
              result_r <= SignBit;
              done_r <= 1'b1;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (quotient[115:63] != '0) result_r <= SignBit;
            else if (neg_r) result_r <= 64'd0 - quotient[63:0];
            else result_r <= quotient[63:0];
            done_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign result = result_r;
endmodule
